/* rtl/sbdw_pkg.sv */
// ----------------------------------------------------------------------------
// sbdw_pkg
// Types, constants and helpers for the stream burning 3x3 window filter.
// ----------------------------------------------------------------------------
package sbdw_pkg;

  localparam int SBDW_MAX_WIDTH  = 1024;
  localparam int NEIGHBOUR_COUNT = 8;
  localparam int HEIGHT_LIMIT    = 4096;

  localparam int ELEV_W     = 32;
  localparam int EPS_W      = 31;
  localparam int GW_W       = 11;
  localparam int GH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [EPS_W-1:0] EPS_RESET = 31'd65536;
  localparam logic [GW_W-1:0]  GW_RESET  = 11'd1024;
  localparam logic [GH_W-1:0]  GH_RESET  = 13'd1024;

  localparam logic signed [ELEV_W-1:0] ELEV_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BURN_MODE   = 2'd0,
    CFG_EPSILON     = 2'd1,
    CFG_GRID_WIDTH  = 2'd2,
    CFG_GRID_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [ELEV_W-1:0] elevation;
    logic                     elevation_missing;
    logic                     stream_present;
    logic                     flush;
  } in_word_t;

  typedef struct packed {
    logic signed [ELEV_W-1:0] burned_elevation;
    logic                     burned_missing;
    logic                     frame_end;
  } out_word_t;

  // one grid cell as held in the line buffers and the window
  typedef struct packed {
    logic                     stream;
    logic                     missing;
    logic signed [ELEV_W-1:0] elev;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  // per-item position info, decided when the word is accepted
  typedef struct packed {
    logic emit;
    logic fend;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } pos_t;

  typedef struct packed {
    logic                     found;
    logic signed [ELEV_W-1:0] value;
  } cand_t;

  // window slots of the 8 neighbours, row-major, center slot skipped
  localparam logic [3:0] NB_IDX [NEIGHBOUR_COUNT] =
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8};
  localparam logic [3:0] CENTER_IDX = 4'd4;

  function automatic cell_t make_cell(input in_word_t w);
    cell_t c;
    if (w.flush) begin
      c.stream  = 1'b0;
      c.missing = 1'b1;
      c.elev    = '0;
    end else begin
      c.stream  = w.stream_present;
      c.missing = w.elevation_missing;
      c.elev    = w.elevation;
    end
    return c;
  endfunction

  function automatic cand_t min_pick(input cand_t a, input cand_t b);
    cand_t r;
    if (a.found && (!b.found || ($signed(a.value) <= $signed(b.value)))) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

/* rtl/sbdw_ram.sv */
// ----------------------------------------------------------------------------
// sbdw_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module sbdw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/sbdw_pos.sv */
// ----------------------------------------------------------------------------
// sbdw_pos
// Raster position counter; works out which window center each word yields
// and which of its neighbours lie inside the grid.
// ----------------------------------------------------------------------------
module sbdw_pos
  import sbdw_pkg::*;
#(
  parameter int MAX_WIDTH = SBDW_MAX_WIDTH,
  parameter int AW        = $clog2(MAX_WIDTH),
  parameter int CW        = $clog2(MAX_WIDTH + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            clr,
  input  logic [CW-1:0]   w_eff,
  input  logic [GH_W-1:0] h_eff,
  output logic [AW-1:0]   col,
  output pos_t            pos
);

  logic [AW-1:0]   col_r, col_nxt;
  logic [GH_W-1:0] row_r, row_nxt;
  logic            c0;
  logic [GH_W:0]   qr;
  logic [GH_W:0]   qr_inc;
  logic [AW:0]     col_inc;

  assign c0      = (col_r == '0);
  // center row lags two rows behind at column zero, one row otherwise
  assign qr      = {1'b0, row_r} - (c0 ? (GH_W+1)'(2) : (GH_W+1)'(1));
  assign qr_inc  = {1'b0, qr[GH_W-1:0]} + (GH_W+1)'(1);
  assign col_inc = {1'b0, col_r} + (AW+1)'(1);

  always_comb begin
    pos.emit     = !qr[GH_W] && (qr[GH_W-1:0] < h_eff);
    pos.top_ok   = !qr[GH_W] && (qr[GH_W-1:0] != '0);
    pos.bot_ok   = qr_inc < {1'b0, h_eff};
    pos.left_ok  = c0 ? (w_eff >= CW'(2)) : (col_r >= AW'(2));
    pos.right_ok = !c0;
    pos.fend     = c0 && ({1'b0, row_r} == ({1'b0, h_eff} + (GH_W+1)'(1)));
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (clr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (adv) begin
      if (pos.fend) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc == (AW+1)'(w_eff)) begin
        col_nxt = '0;
        row_nxt = row_r + GH_W'(1);
      end else begin
        col_nxt = col_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col = col_r;

endmodule

/* rtl/sbdw_window.sv */
// ----------------------------------------------------------------------------
// sbdw_window
// Input register, two line buffers in one RAM and the 3x3 window register.
// ----------------------------------------------------------------------------
module sbdw_window
  import sbdw_pkg::*;
#(
  parameter int MAX_WIDTH = SBDW_MAX_WIDTH,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  in_word_t      in_data,
  output logic          in_stall,
  output logic          accept,
  input  logic [AW-1:0] col,
  input  pos_t          pos,
  input  logic          rdy3,
  output logic          s2_valid,
  output pos_t          s2_pos,
  output cell_t [8:0]   win
);

  logic          s1_valid_r;
  cell_t         s1_cell_r;
  logic [AW-1:0] s1_col_r;
  pos_t          s1_pos_r;
  logic          fwd_r;
  cell_t         fwd_up_r;
  cell_t         fwd_mid_r;
  logic          s2_valid_r;
  pos_t          s2_pos_r;
  cell_t [8:0]   win_r;

  logic                  rdy1, rdy2, mv1;
  logic [2*CELL_W-1:0]   rd_data;
  cell_t                 up_eff, mid_eff;

  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign mv1      = s1_valid_r && rdy2;
  assign accept   = in_valid && rdy1;
  assign in_stall = !rdy1;

  // upper line in the high half, middle line in the low half
  sbdw_ram #(
    .WIDTH (2*CELL_W),
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_lines (
    .clk   (clk),
    .we    (mv1),
    .waddr (s1_col_r),
    .wdata ({mid_eff, s1_cell_r}),
    .re    (accept),
    .raddr (col),
    .rdata (rd_data)
  );

  // a one-pixel-wide grid reads back the column written in the same cycle
  assign up_eff  = fwd_r ? fwd_up_r  : cell_t'(rd_data[2*CELL_W-1:CELL_W]);
  assign mid_eff = fwd_r ? fwd_mid_r : cell_t'(rd_data[CELL_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
      s2_valid_r <= 1'b0;
      win_r      <= '0;
    end else begin
      if (rdy1) begin
        s1_valid_r <= in_valid;
      end
      if (accept) begin
        fwd_r <= mv1 && (s1_col_r == col);
      end
      if (rdy2) begin
        s2_valid_r <= s1_valid_r && s1_pos_r.emit;
      end
      if (mv1) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= up_eff;
        win_r[3] <= win_r[4];
        win_r[4] <= win_r[5];
        win_r[5] <= mid_eff;
        win_r[6] <= win_r[7];
        win_r[7] <= win_r[8];
        win_r[8] <= s1_cell_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cell_r <= make_cell(in_data);
      s1_col_r  <= col;
      s1_pos_r  <= pos;
      fwd_up_r  <= mid_eff;
      fwd_mid_r <= s1_cell_r;
    end
    if (mv1) begin
      s2_pos_r <= s1_pos_r;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_pos   = s2_pos_r;
  assign win      = win_r;

endmodule

/* rtl/sbdw_burn.sv */
// ----------------------------------------------------------------------------
// sbdw_burn
// Neighbour minimum in two registered halves, then the epsilon subtract
// with saturation into the output register.
// ----------------------------------------------------------------------------
module sbdw_burn
  import sbdw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s2_valid,
  input  pos_t             s2_pos,
  input  cell_t [8:0]      win,
  input  logic             burn_mode,
  input  logic [EPS_W-1:0] epsilon,
  output logic             rdy3,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_data
);

  logic      s3_valid_r;
  cand_t     cand_r [2];
  cell_t     s3_ctr_r;
  logic      s3_fend_r;
  logic      out_valid_r;
  out_word_t out_data_r;

  logic      rdy4, mv2, mv3;
  logic      nb_ok [NEIGHBOUR_COUNT];
  cand_t     lvl0 [NEIGHBOUR_COUNT];
  cand_t     lvl1 [NEIGHBOUR_COUNT/2];
  cand_t     lvl2 [2];
  cand_t     best;
  logic signed [ELEV_W-1:0] base;
  logic [ELEV_W:0]          diff;
  logic signed [ELEV_W-1:0] sat;
  logic                     burn;

  assign rdy4 = !out_valid_r || !out_stall;
  assign rdy3 = !s3_valid_r || rdy4;
  assign mv2  = s2_valid && rdy3;
  assign mv3  = s3_valid_r && rdy4;

  always_comb begin
    nb_ok[0] = s2_pos.top_ok && s2_pos.left_ok;
    nb_ok[1] = s2_pos.top_ok;
    nb_ok[2] = s2_pos.top_ok && s2_pos.right_ok;
    nb_ok[3] = s2_pos.left_ok;
    nb_ok[4] = s2_pos.right_ok;
    nb_ok[5] = s2_pos.bot_ok && s2_pos.left_ok;
    nb_ok[6] = s2_pos.bot_ok;
    nb_ok[7] = s2_pos.bot_ok && s2_pos.right_ok;
    for (int k = 0; k < NEIGHBOUR_COUNT; k++) begin
      lvl0[k].found = burn_mode && nb_ok[k] &&
                      !win[NB_IDX[k]].missing && !win[NB_IDX[k]].stream;
      lvl0[k].value = win[NB_IDX[k]].elev;
    end
    for (int k = 0; k < NEIGHBOUR_COUNT/2; k++) begin
      lvl1[k] = min_pick(lvl0[2*k], lvl0[2*k+1]);
    end
    for (int k = 0; k < 2; k++) begin
      lvl2[k] = min_pick(lvl1[2*k], lvl1[2*k+1]);
    end
  end

  always_comb begin
    best = min_pick(cand_r[0], cand_r[1]);
    burn = s3_ctr_r.stream && !s3_ctr_r.missing;
    base = best.found ? best.value : s3_ctr_r.elev;
    diff = {base[ELEV_W-1], base} - {2'b00, epsilon};
    // only underflow is possible, clamp to the most negative value
    sat  = (diff[ELEV_W] != diff[ELEV_W-1]) ? ELEV_MIN : diff[ELEV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy3) begin
        s3_valid_r <= s2_valid;
      end
      if (rdy4) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv2) begin
      cand_r[0] <= lvl2[0];
      cand_r[1] <= lvl2[1];
      s3_ctr_r  <= win[CENTER_IDX];
      s3_fend_r <= s2_pos.fend;
    end
    if (mv3) begin
      out_data_r.burned_elevation <= burn ? sat : s3_ctr_r.elev;
      out_data_r.burned_missing   <= s3_ctr_r.missing;
      out_data_r.frame_end        <= s3_fend_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/stream_burn_dem_window.sv */
// ----------------------------------------------------------------------------
// stream_burn_dem_window
// A word's result passes the input, window, minimum and output registers
// after the word that completes its window is accepted; that word comes one
// row plus one pixel after the pixel. One word per cycle while out_stall is
// low, set by the single read and write port of the line buffer RAM. Reset
// is synchronous; it clears control state and registers, not line buffers.
// ----------------------------------------------------------------------------
module stream_burn_dem_window
  import sbdw_pkg::*;
#(
  parameter int MAX_WIDTH = SBDW_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int MW = (CW > GW_W) ? CW : GW_W;

  logic             burn_mode_r;
  logic [EPS_W-1:0] epsilon_r;
  logic [GW_W-1:0]  grid_width_r;
  logic [GH_W-1:0]  grid_height_r;

  logic            size_wr;
  logic [MW-1:0]   gw_ext, w_cl;
  logic [CW-1:0]   w_eff;
  logic [GH_W-1:0] h_eff;
  logic [AW-1:0]   col;
  pos_t            pos;
  logic            accept;
  logic            rdy3;
  logic            s2_valid;
  pos_t            s2_pos;
  cell_t [8:0]     win;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burn_mode_r   <= 1'b0;
      epsilon_r     <= EPS_RESET;
      grid_width_r  <= GW_RESET;
      grid_height_r <= GH_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        CFG_BURN_MODE:   burn_mode_r   <= cfg_wdata[0];
        CFG_EPSILON:     epsilon_r     <= cfg_wdata[EPS_W-1:0];
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata[GW_W-1:0];
        CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata[GH_W-1:0];
        default: ;
      endcase
    end
  end

  // a size write restarts the frame
  assign size_wr = cfg_we && ((cfg_reg_t'(cfg_idx) == CFG_GRID_WIDTH) ||
                              (cfg_reg_t'(cfg_idx) == CFG_GRID_HEIGHT));

  always_comb begin
    gw_ext = MW'(grid_width_r);
    if (gw_ext == '0) begin
      w_cl = MW'(1);
    end else if (gw_ext > MW'(MAX_WIDTH)) begin
      w_cl = MW'(MAX_WIDTH);
    end else begin
      w_cl = gw_ext;
    end
    w_eff = w_cl[CW-1:0];
    if (grid_height_r == '0) begin
      h_eff = GH_W'(1);
    end else if (grid_height_r > GH_W'(HEIGHT_LIMIT)) begin
      h_eff = GH_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = grid_height_r;
    end
  end

  sbdw_pos #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW),
    .CW        (CW)
  ) u_pos (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (accept),
    .clr   (size_wr),
    .w_eff (w_eff),
    .h_eff (h_eff),
    .col   (col),
    .pos   (pos)
  );

  sbdw_window #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .accept   (accept),
    .col      (col),
    .pos      (pos),
    .rdy3     (rdy3),
    .s2_valid (s2_valid),
    .s2_pos   (s2_pos),
    .win      (win)
  );

  sbdw_burn u_burn (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_valid  (s2_valid),
    .s2_pos    (s2_pos),
    .win       (win),
    .burn_mode (burn_mode_r),
    .epsilon   (epsilon_r),
    .rdy3      (rdy3),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col} < (AW+1)'(w_eff))
    else $error("column position outside the grid row");

  a_fend_emits: assert property (@(posedge clk) disable iff (!rst_n)
    pos.fend |-> pos.emit)
    else $error("frame end on a word without a result");

  a_fend_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && pos.fend |=> col == '0)
    else $error("frame did not restart after its last pixel");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output register is empty");

endmodule
